[hdl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// expression must never be true at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

[hdl/sees_pkg.sv]
package sees_pkg;

	// item and result field widths
	localparam int CLASS_W = 3;
	localparam int RC_W    = 40;
	localparam int W_W     = 40;
	localparam int TOL_W   = 39;
	localparam int IDX_W   = 16;
	localparam int SEEN_W  = 17;

	// bound classes
	localparam logic [CLASS_W-1:0] CLS_BASIC = 3'd0;
	localparam logic [CLASS_W-1:0] CLS_LOWER = 3'd1;
	localparam logic [CLASS_W-1:0] CLS_UPPER = 3'd2;
	localparam logic [CLASS_W-1:0] CLS_FREE  = 3'd3;

	localparam logic [W_W-1:0]    ONE_Q24    = 40'h00_0100_0000;
	localparam logic [TOL_W-1:0]  TOL_RESET  = 39'd17;
	localparam logic [SEEN_W-1:0] SEEN_MAX   = '1;

	localparam int MAX_VARS_DEF = 65536;

	// configuration port
	localparam int DATA_W = 64;
	localparam int ADDR_W = 4;
	localparam logic REG_TOLERANCE = 1'b0;

	// shared multiplier: 80-bit operand times 40-bit operand, 16 bits a cycle
	localparam int MUL_A_W = 2 * RC_W;
	localparam int MUL_B_W = W_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int DIGIT_W = 16;
	localparam int DIGITS  = (MUL_B_W + DIGIT_W - 1) / DIGIT_W;
	localparam int CNT_W   = $clog2(DIGITS + 1);

	typedef enum logic [1:0] {
		OP_SQ  = 2'd0,
		OP_RHS = 2'd1,
		OP_LHS = 2'd2
	} mul_op_t;

	typedef struct packed {
		logic    load;
		logic    eval;
		logic    mul_start;
		mul_op_t op;
		logic    mul_take;
		logic    update;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		logic attractive;
		logic have_best;
		logic last;
		logic mul_done;
		logic out_busy;
	} status_t;

endpackage

[hdl/sees_in_if.sv]
interface sees_in_if;
	import sees_pkg::*;

	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] var_class;
	logic signed [RC_W-1:0] rcost;
	logic [W_W-1:0]     edge_weight;
	logic               last_item;

	modport source (output valid, var_class, rcost, edge_weight, last_item,
		input ready);
	modport sink (input valid, var_class, rcost, edge_weight, last_item,
		output ready);
endinterface

[hdl/sees_out_if.sv]
interface sees_out_if;
	import sees_pkg::*;

	logic              valid;
	logic              ready;
	logic              found;
	logic [IDX_W-1:0]  entering_index;
	logic [SEEN_W-1:0] scanned_count;

	modport source (output valid, found, entering_index, scanned_count, input ready);
	modport sink (input valid, found, entering_index, scanned_count, output ready);
endinterface

[hdl/sees_mul.sv]
module sees_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sees_pkg::MUL_A_W-1:0] a,
	input  logic [sees_pkg::MUL_B_W-1:0] b,
	output logic                        done,
	output logic [sees_pkg::PROD_W-1:0]  product
);
	import sees_pkg::*;

	localparam int BQ_W   = DIGITS * DIGIT_W;
	localparam int PART_W = MUL_A_W + DIGIT_W;

	logic [MUL_A_W-1:0] a_q;
	logic [BQ_W-1:0]    b_q;
	logic [PROD_W-1:0]  acc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [PART_W-1:0]  part;
	logic [PROD_W-1:0]  acc_next;

	// high digit first: shift the sum left and add the next partial product
	assign part     = PART_W'(a_q) * PART_W'(b_q[BQ_W-1 -: DIGIT_W]);
	assign acc_next = {acc_q[PROD_W-DIGIT_W-1:0], DIGIT_W'(0)} + PROD_W'(part);

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= BQ_W'(b);
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			b_q   <= b_q << DIGIT_W;
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && (cnt_q == CNT_W'(1));
			if (start)
				cnt_q <= CNT_W'(DIGITS);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule

[hdl/sees_dp.sv]
module sees_dp #(
	parameter int MAX_VARS = sees_pkg::MAX_VARS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sees_pkg::cmd_t                  cmd,
	output sees_pkg::status_t               status,
	input  logic [sees_pkg::TOL_W-1:0]      tolerance,
	input  logic [sees_pkg::CLASS_W-1:0]    var_class,
	input  logic signed [sees_pkg::RC_W-1:0] rcost,
	input  logic [sees_pkg::W_W-1:0]        edge_weight,
	input  logic                            last_item,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic                            found,
	output logic [sees_pkg::IDX_W-1:0]      entering_index,
	output logic [sees_pkg::SEEN_W-1:0]     scanned_count
);
	import sees_pkg::*;

	localparam int PW = $clog2(MAX_VARS + 1);

	// current item
	logic [CLASS_W-1:0]     cls_q;
	logic signed [RC_W-1:0] rc_q;
	logic [RC_W-1:0]        mag_q;
	logic [W_W-1:0]         w_q;
	logic                   last_q;
	logic [IDX_W-1:0]       idx_q;

	// scan state
	logic [PW-1:0]      position_q;
	logic [SEEN_W-1:0]  seen_q;
	logic               have_best_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [MUL_A_W-1:0] best_sq_q;
	logic [W_W-1:0]     best_w_q;

	// products
	logic [MUL_A_W-1:0] sq_q;
	logic [PROD_W-1:0]  lhs_q;
	logic [PROD_W-1:0]  rhs_q;

	// result register
	logic              res_valid_q;
	logic              found_q;
	logic [IDX_W-1:0]  index_q;
	logic [SEEN_W-1:0] count_q;

	logic                   in_range;
	logic [PW+IDX_W-1:0]    pos_ext;
	logic signed [RC_W:0]   rc_s;
	logic signed [RC_W:0]   tol_s;
	logic                   attr_cls;
	logic [MUL_A_W-1:0]     mul_a;
	logic [MUL_B_W-1:0]     mul_b;
	logic                   mul_done;
	logic [PROD_W-1:0]      product;

	assign in_range = position_q < PW'(MAX_VARS);
	assign pos_ext  = {{IDX_W{1'b0}}, position_q};
	assign rc_s     = (RC_W+1)'(rc_q);
	assign tol_s    = signed'({2'b00, tolerance});

	always_comb begin
		case (cls_q)
			CLS_LOWER: attr_cls = rc_s < -tol_s;
			CLS_UPPER: attr_cls = rc_s > tol_s;
			CLS_FREE:  attr_cls = {1'b0, mag_q} > {2'b00, tolerance};
			default:   attr_cls = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd.op)
			OP_SQ: begin
				mul_a = MUL_A_W'(mag_q);
				mul_b = mag_q;
			end
			OP_RHS: begin
				mul_a = best_sq_q;
				mul_b = w_q;
			end
			OP_LHS: begin
				mul_a = sq_q;
				mul_b = best_w_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	sees_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (product)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cls_q  <= var_class;
			rc_q   <= rcost;
			mag_q  <= rcost[RC_W-1] ? RC_W'(-rcost) : rcost;
			w_q    <= (edge_weight == '0) ? ONE_Q24 : edge_weight;
			last_q <= last_item;
		end
		if (cmd.eval)
			idx_q <= pos_ext[IDX_W-1:0];
		if (cmd.mul_take) begin
			case (cmd.op)
				OP_SQ:   sq_q  <= product[MUL_A_W-1:0];
				OP_RHS:  rhs_q <= product;
				OP_LHS:  lhs_q <= product;
				default: sq_q  <= sq_q;
			endcase
		end
		if (cmd.update && (!have_best_q || lhs_q > rhs_q)) begin
			best_idx_q <= idx_q;
			best_sq_q  <= sq_q;
			best_w_q   <= w_q;
		end
		if (cmd.emit) begin
			found_q <= have_best_q;
			index_q <= have_best_q ? best_idx_q : '0;
			count_q <= seen_q;
		end
	end

	// scan state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q  <= '0;
			seen_q      <= '0;
			have_best_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.eval) begin
				if (in_range)
					position_q <= position_q + PW'(1);
				if (in_range && cls_q != CLS_BASIC && seen_q != SEEN_MAX)
					seen_q <= seen_q + SEEN_W'(1);
			end
			if (cmd.update)
				have_best_q <= 1'b1;
			if (cmd.emit) begin
				position_q  <= '0;
				seen_q      <= '0;
				have_best_q <= 1'b0;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign status.attractive = in_range && attr_cls;
	assign status.have_best  = have_best_q;
	assign status.last       = last_q;
	assign status.mul_done   = mul_done;
	assign status.out_busy   = res_valid_q && !res_ready;

	assign res_valid      = res_valid_q;
	assign found          = found_q;
	assign entering_index = index_q;
	assign scanned_count  = count_q;
endmodule

[hdl/sees_ctrl.sv]
module sees_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  sees_pkg::status_t status,
	output sees_pkg::cmd_t    cmd
);
	import sees_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EVAL   = 6'b000010,
		S_MSTART = 6'b000100,
		S_MWAIT  = 6'b001000,
		S_CMP    = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t  state_q, state_d;
	mul_op_t op_q, op_d;

	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		cmd           = '0;
		cmd.op        = op_q;
		item_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (status.attractive) begin
					op_d    = OP_SQ;
					state_d = S_MSTART;
				end else if (status.last) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MSTART: begin
				cmd.mul_start = 1'b1;
				state_d       = S_MWAIT;
			end
			S_MWAIT: begin
				if (status.mul_done) begin
					cmd.mul_take = 1'b1;
					case (op_q)
						OP_SQ: begin
							if (status.have_best) begin
								op_d    = OP_RHS;
								state_d = S_MSTART;
							end else begin
								state_d = S_CMP;
							end
						end
						OP_RHS: begin
							op_d    = OP_LHS;
							state_d = S_MSTART;
						end
						default: state_d = S_CMP;
					endcase
				end
			end
			S_CMP: begin
				cmd.update = 1'b1;
				state_d    = status.last ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_SQ;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end
endmodule

[hdl/steepest_edge_entering_select.sv]
// channel   dir  handshake        payload
// item      in   valid / ready    var_class, rcost, edge_weight, last_item
// result    out  valid / ready    found, entering_index, scanned_count
// apb       in   psel / penable   tolerance at byte address 0, 64-bit data
//
// an item that is basic or not attractive is only loaded and evaluated
// an attractive item runs one product when the scan holds no leader yet, else three:
// the 80x16 multiplier computes each product in turn (square, then two cross products)
// the last item of a scan then also loads the result register
// the block waits before that load while an earlier result is still not taken
// reset clears the scan and sets tolerance to 17; no clearing pass is needed
module steepest_edge_entering_select #(
	parameter int MAX_VARS = sees_pkg::MAX_VARS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sees_pkg::ADDR_W-1:0]  paddr,
	input  logic [sees_pkg::DATA_W-1:0]  pwdata,
	output logic [sees_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	sees_in_if.sink                      item,
	sees_out_if.source                   result
);
	import sees_pkg::*;

	// tolerance register, one 8-byte slot; only the slot bit is decoded
	logic [TOL_W-1:0] tol_q;
	logic             reg_hit;
	logic             reg_wr;

	// controller to datapath
	cmd_t    cmd;
	status_t status;

	assign reg_hit = paddr[ADDR_W-1] == REG_TOLERANCE;
	assign reg_wr  = psel && penable && pwrite && reg_hit;
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? DATA_W'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= TOL_RESET;
		else if (reg_wr)
			tol_q <= pwdata[TOL_W-1:0];
	end

	// sequencer: accepts items, runs the multiplier, loads the result
	sees_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	// scan state, leader, products and result register
	sees_dp #(
		.MAX_VARS (MAX_VARS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.tolerance      (tol_q),
		.var_class      (item.var_class),
		.rcost          (item.rcost),
		.edge_weight    (item.edge_weight),
		.last_item      (item.last_item),
		.res_valid      (result.valid),
		.res_ready      (result.ready),
		.found          (result.found),
		.entering_index (result.entering_index),
		.scanned_count  (result.scanned_count)
	);
endmodule

[hdl/sees_checker.sv]
`include "assert_macros.svh"

module sees_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [63:0] pwdata,
	input logic [63:0] prdata,
	input logic        result_valid,
	input logic        result_ready,
	input logic        result_found,
	input logic [15:0] result_index,
	input logic [16:0] result_count
);
	// a result waiting at the port stays offered
	`ASSERT_CLK(a_res_hold, clk, arst_n, result_valid && !result_ready |=> result_valid, "result dropped while stalled")

	// no winner means index zero
	`ASSERT_NEVER(a_notfound_idx, clk, arst_n, result_valid && !result_found && result_index != 16'd0, "index nonzero without a winner")

	// a winner was counted as nonbasic
	`ASSERT_NEVER(a_found_count, clk, arst_n, result_valid && result_found && result_count == 17'd0, "winner with zero scanned count")

	// tolerance reads back what was written
	`ASSERT_CLK(a_tol_readback, clk, arst_n, (psel && penable && pwrite && paddr[3] == 1'b0) ##1 (paddr[3] == 1'b0) |-> prdata[38:0] == $past(pwdata[38:0]), "tolerance readback mismatch")
endmodule

bind steepest_edge_entering_select sees_checker u_sees_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_found (result.found),
	.result_index (result.entering_index),
	.result_count (result.scanned_count)
);
